[sv/ptd_pkg.sv]
// Shared types and constants for the trial-division primality tester.
// No dependencies; used by ptd_rem_serial and prime_test_trial_division.
package ptd_pkg;

	localparam int unsigned FIRST_DIVISOR = 2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_TEST = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} div_sts_t;

endpackage

[sv/ptd_rem_serial.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle, MSB first.
// Depends on ptd_pkg for the control and status structs.
module ptd_rem_serial #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptd_pkg::div_ctrl_t   ctrl,
	input  logic [W-1:0]         dividend,
	input  logic [W-1:0]         divisor,
	output ptd_pkg::div_sts_t    sts
);

	localparam int CntW = $clog2(W + 1);

	logic [W-1:0]    sh_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    div_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            zero_q;

	logic [W:0]      trial;
	logic [W:0]      diff;
	logic [W-1:0]    rem_next;

	assign trial    = {rem_q, sh_q[W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sh_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q   <= {sh_q[W-2:0], 1'b0};
			rem_q  <= rem_next;
			zero_q <= (rem_next == '0);
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.zero = zero_q;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> busy_q && !done_q)
		else $error("remainder unit did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished division");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("busy with zero bit count");
`endif

endmodule

[sv/prime_test_trial_division.sv]
// Trial-division primality tester: one candidate in, one prime flag out.
// Divisors are tried from 2 upward while their square does not exceed the candidate, up to
// 2^(NUMBER_WIDTH/2) divisors; each is checked by the bit-serial remainder unit.
// One candidate at a time; a new request is taken while the previous result waits.
// Asynchronous active-low reset clears the sequencer and the output valid.
// Depends on ptd_pkg and ptd_rem_serial.
module prime_test_trial_division #(
	parameter int NUMBER_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     s_tdata,  // [NUMBER_WIDTH-1:0] candidate
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata   // [0] prime_flag
);

	localparam int SqW = NUMBER_WIDTH + 2;

	ptd_pkg::state_t    state_q;
	ptd_pkg::div_ctrl_t div_ctrl;
	ptd_pkg::div_sts_t  div_sts;

	logic [NUMBER_WIDTH-1:0] n_q;
	logic [NUMBER_WIDTH-1:0] d_q;
	logic [SqW-1:0]          sq_q;
	logic                    verdict_q;
	logic                    result_q;
	logic                    out_valid_q;
	logic                    out_free;

	assign s_tready = (state_q == ptd_pkg::S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign div_ctrl.start = (state_q == ptd_pkg::S_TEST) && (n_q >= NUMBER_WIDTH'(2))
		&& (sq_q <= {2'b00, n_q});

	ptd_rem_serial #(.W(NUMBER_WIDTH)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (n_q),
		.divisor  (d_q),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptd_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ptd_pkg::S_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ptd_pkg::S_IDLE: begin
					if (s_tvalid)
						state_q <= ptd_pkg::S_TEST;
				end
				ptd_pkg::S_TEST: begin
					if (!div_ctrl.start)
						state_q <= ptd_pkg::S_FIN;
					else
						state_q <= ptd_pkg::S_DIV;
				end
				ptd_pkg::S_DIV: begin
					if (div_sts.done)
						state_q <= div_sts.zero ? ptd_pkg::S_FIN : ptd_pkg::S_TEST;
				end
				ptd_pkg::S_FIN: begin
					if (out_free)
						state_q <= ptd_pkg::S_IDLE;
				end
				default: state_q <= ptd_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ptd_pkg::S_IDLE: begin
				if (s_tvalid) begin
					n_q  <= s_tdata[NUMBER_WIDTH-1:0];
					d_q  <= NUMBER_WIDTH'(ptd_pkg::FIRST_DIVISOR);
					sq_q <= SqW'(ptd_pkg::FIRST_DIVISOR * ptd_pkg::FIRST_DIVISOR);
				end
			end
			ptd_pkg::S_TEST: begin
				if (n_q < NUMBER_WIDTH'(2))
					verdict_q <= 1'b0;
				else if (sq_q > {2'b00, n_q})
					verdict_q <= 1'b1;
			end
			ptd_pkg::S_DIV: begin
				if (div_sts.done) begin
					if (div_sts.zero)
						verdict_q <= 1'b0;
					d_q  <= d_q + NUMBER_WIDTH'(1);
					sq_q <= sq_q + {1'b0, d_q, 1'b1};
				end
			end
			ptd_pkg::S_FIN: begin
				if (out_free)
					result_q <= verdict_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, result_q};

`ifndef SYNTHESIS
	a_accept_test: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ptd_pkg::S_TEST)
		else $error("accepted request did not enter test");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ptd_pkg::S_DIV)
		else $error("remainder finished outside divide state");
	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptd_pkg::S_TEST && n_q < NUMBER_WIDTH'(2)
		|=> state_q == ptd_pkg::S_FIN && !verdict_q)
		else $error("zero or one not reported composite");
	a_start_only_test: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.start |-> !div_sts.busy)
		else $error("divider started while busy");
`endif

endmodule

[sim/tb_top.sv]
// Testbench for prime_test_trial_division: a table of directed candidates, then random ones,
// each prime flag checked against a known table flag or an in-bench trial-division predictor.
// Depends on ptd_pkg, ptd_rem_serial and prime_test_trial_division.
module tb_top;

	localparam int NUMBER_WIDTH = 16;
	localparam int DATA_W       = ((NUMBER_WIDTH + 7) / 8) * 8;
	localparam int DIR_ROWS     = 18;
	localparam int RAND_ITEMS   = 122;
	localparam int TOTAL_ITEMS  = DIR_ROWS + RAND_ITEMS;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 12000;
	localparam int DRAIN_CYCLES = 6000;

	typedef struct {
		logic [NUMBER_WIDTH-1:0] cand;
		bit                      known;
		logic                    want;
	} cand_row_t;

	cand_row_t cand_tab [DIR_ROWS] = '{
		'{16'd0,     1'b1, 1'b0},
		'{16'd1,     1'b1, 1'b0},
		'{16'd2,     1'b1, 1'b1},
		'{16'd3,     1'b1, 1'b1},
		'{16'd4,     1'b1, 1'b0},
		'{16'd5,     1'b0, 1'b0},
		'{16'd9,     1'b0, 1'b0},
		'{16'd25,    1'b0, 1'b0},
		'{16'd49,    1'b0, 1'b0},
		'{16'd65535, 1'b1, 1'b0},
		'{16'd65534, 1'b1, 1'b0},
		'{16'd65521, 1'b0, 1'b0},
		'{16'd65025, 1'b0, 1'b0},
		'{16'd63001, 1'b0, 1'b0},
		'{16'd32749, 1'b0, 1'b0},
		'{16'h8000,  1'b1, 1'b0},
		'{16'h5555,  1'b0, 1'b0},
		'{16'hAAAA,  1'b1, 1'b0}
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic              m_tready = 1'b0;
	wire               s_tready;
	wire               m_tvalid;
	wire  [7:0]        m_tdata;   // [0] prime_flag

	logic        prime_flag_q [$];
	logic        want_flag;
	int unsigned err_count = 0;

	always #5 clk = ~clk;

	prime_test_trial_division #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	function automatic logic prime_flag_of(input logic [NUMBER_WIDTH-1:0] cand);
		int unsigned n;
		int unsigned d;
		n = cand;
		if (n < 2) return 1'b0;
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int unsigned idle_draw(input int unsigned idx);
		if ((idx / 20) % 4 == 1) return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [NUMBER_WIDTH-1:0] random_candidate();
		int unsigned k;
		case ($urandom_range(0, 7))
			0, 1, 2: return NUMBER_WIDTH'($urandom_range(0, 65535));
			3:       return NUMBER_WIDTH'($urandom_range(0, 300));
			4: begin
				k = $urandom_range(2, 255);
				return NUMBER_WIDTH'(k * k);
			end
			5: begin
				k = $urandom_range(2, 253);
				return NUMBER_WIDTH'(k * (k + 2));
			end
			6:       return NUMBER_WIDTH'($urandom_range(65400, 65535));
			default: return NUMBER_WIDTH'($urandom | 1);
		endcase
	endfunction

	task automatic send_request(input logic [NUMBER_WIDTH-1:0] cand, input logic want,
			input int unsigned idx);
		int unsigned gap;
		gap = idle_draw(idx);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(cand);
		do @(posedge clk); while (!s_tready);
		prime_flag_q.push_back(want);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (prime_flag_q.size() == 0) begin
				$error("prime_flag: result with no request waiting, got %0d", m_tdata[0]);
				err_count++;
			end else begin
				want_flag = prime_flag_q.pop_front();
				if (m_tdata[0] !== want_flag) begin
					$error("prime_flag: expected %0d, got %0d", want_flag, m_tdata[0]);
					err_count++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			begin
				logic [NUMBER_WIDTH-1:0] cand;
				for (int i = 0; i < DIR_ROWS; i++) begin
					send_request(cand_tab[i].cand,
						cand_tab[i].known ? cand_tab[i].want : prime_flag_of(cand_tab[i].cand), i);
				end
				for (int i = 0; i < RAND_ITEMS; i++) begin
					cand = random_candidate();
					send_request(cand, prime_flag_of(cand), DIR_ROWS + i);
				end
				s_tvalid <= 1'b0;
			end
			begin
				int unsigned gap;
				int unsigned hold_cnt;
				for (int r = 0; r < TOTAL_ITEMS; r++) begin
					if (r == HOLD_AT) begin
						m_tready <= 1'b0;
						for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
					end else begin
						gap = idle_draw(r + 7);
						if (gap > 0) begin
							m_tready <= 1'b0;
							repeat (gap) @(posedge clk);
						end
					end
					m_tready <= 1'b1;
					do @(posedge clk); while (!m_tvalid);
				end
			end
		join
		while (prime_flag_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
